@@ rtl/c2r_pkg.sv @@
`default_nettype none
package c2r_pkg;
   localparam int ACC_W = 40;
   localparam int VAL_W = 16;
   localparam logic [1:0] OP_WEIGHT = 2'd0;
   localparam logic [1:0] OP_BIAS   = 2'd1;
   localparam logic [1:0] OP_PIXEL  = 2'd2;
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // datapath commands
   typedef struct packed {
      logic store_pixel;   // write line store at current position
      logic adv_pos;       // advance chan/col/row counters
      logic clr_acc;       // zero accumulator, zero window counters
      logic issue;         // launch one read + product pipe step
      logic next_filter;   // restart window walk for next filter
      logic add_bias;      // fold bias into accumulator
      logic load_out;      // capture result into output register
   } c2r_cmd_type;

   // datapath status
   typedef struct packed {
      logic pos_last_chan;  // current pixel is last channel of position
      logic pos_in_window;  // position produces outputs
      logic walk_done;      // last window element issued
      logic pipe_empty;     // no products in flight
      logic filter_last;    // current filter is last
   } c2r_stat_type;

   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a, input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] s;
      begin
         s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
         if (s[ACC_W] != s[ACC_W-1])
            sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
         else
            sat_add = s[ACC_W-1:0];
      end
   endfunction
endpackage
`default_nettype wire

@@ rtl/c2r_datapath.sv @@
`default_nettype none
module c2r_datapath
   import c2r_pkg::*;
#(
   parameter int IMG_SIZE = 43,
   parameter int CHANNELS = 1,
   parameter int KERNEL   = 11,
   parameter int FILTERS  = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [1:0]         req_op,
   input  wire logic [12:0]        req_table_index,
   input  wire logic signed [15:0] req_value,
   input  wire logic               req_take,
   input  wire c2r_cmd_type        cmd,
   output c2r_stat_type            stat,
   output logic [14:0]             rsp_activation,
   output logic [5:0]              rsp_filter_index,
   output logic [5:0]              rsp_out_row,
   output logic [5:0]              rsp_out_col,
   output logic                    rsp_last
);
   localparam int WDEPTH = KERNEL * KERNEL * CHANNELS * FILTERS;
   localparam int LPOS   = IMG_SIZE * (KERNEL - 1) + KERNEL;
   localparam int LDEPTH = LPOS * CHANNELS;
   localparam int WA = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int LA = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
   localparam int PA = (LPOS > 1) ? $clog2(LPOS) : 1;
   localparam int IA = $clog2(IMG_SIZE);
   localparam int KA = (KERNEL > 1) ? $clog2(KERNEL) : 1;
   localparam int CA = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int FA = (FILTERS > 1) ? $clog2(FILTERS) : 1;

   logic signed [15:0] weight_mem [WDEPTH];
   logic signed [15:0] bias_mem [FILTERS];
   logic signed [15:0] line_mem [LDEPTH];

   // position counters
   logic [CA-1:0] chan_ff;
   logic [IA-1:0] row_ff, col_ff;
   logic [PA-1:0] slot_ff;     // (row*IMG+col) mod LPOS
   // window walk counters
   logic [KA-1:0] wr_ff, wc_ff;
   logic [CA-1:0] wch_ff;
   logic [FA-1:0] f_ff;
   logic [PA-1:0] wbase_ff;    // slot of window row start
   logic [PA-1:0] wslot_ff;    // slot of current window element
   logic [WA-1:0] waddr_ff;    // weight address of element, filter 0 based
   logic [PA-1:0] topleft_ff;  // slot of window top-left
   logic [IA-1:0] r0_ff, c0_ff;
   // pipeline
   logic          v1_ff, v2_ff;
   logic signed [15:0] px_ff, w_ff;
   logic signed [31:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [15:0] bias_ff;

   function automatic logic [PA-1:0] slot_add(input logic [PA-1:0] s, input int unsigned d);
      logic [PA:0] t;
      begin
         t = {1'b0, s} + (PA+1)'(d);
         if (t >= (PA+1)'(LPOS)) t = t - (PA+1)'(LPOS);
         slot_add = t[PA-1:0];
      end
   endfunction

   // loads and pixel store
   always_ff @(posedge clock) begin
      if (req_take && req_op == OP_WEIGHT && {19'd0, req_table_index} < WDEPTH)
         weight_mem[WA'(req_table_index)] <= req_value;
      if (req_take && req_op == OP_BIAS && {19'd0, req_table_index} < FILTERS)
         bias_mem[req_table_index[FA-1:0]] <= req_value;
      if (cmd.store_pixel)
         line_mem[LA'(slot_ff * CHANNELS + chan_ff)] <= req_value;
   end

   // position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= '0; row_ff <= '0; col_ff <= '0; slot_ff <= '0;
      end else if (cmd.adv_pos) begin
         if (32'(chan_ff) + 1 < CHANNELS) begin
            chan_ff <= chan_ff + 1'b1;
         end else begin
            chan_ff <= '0;
            if (32'(col_ff) + 1 < IMG_SIZE) begin
               col_ff <= col_ff + 1'b1;
               slot_ff <= slot_add(slot_ff, 1);
            end else begin
               col_ff <= '0;
               if (32'(row_ff) + 1 < IMG_SIZE) begin
                  row_ff <= row_ff + 1'b1;
                  slot_ff <= slot_add(slot_ff, 1);
               end else begin
                  row_ff <= '0;
                  slot_ff <= '0;
               end
            end
         end
      end
   end

   assign stat.pos_last_chan = (32'(chan_ff) + 1 >= CHANNELS);
   assign stat.pos_in_window = (32'(row_ff) >= KERNEL - 1) && (32'(col_ff) >= KERNEL - 1);

   // top-left slot: current slot + 1 (mod LPOS) since LPOS holds exactly the window span
   logic last_elem;
   assign last_elem = (32'(wr_ff) == KERNEL - 1) && (32'(wc_ff) == KERNEL - 1)
                      && (32'(wch_ff) == CHANNELS - 1);
   assign stat.walk_done   = last_elem;
   assign stat.pipe_empty  = !v1_ff && !v2_ff;
   assign stat.filter_last = (32'(f_ff) == FILTERS - 1);

   // window walk
   always_ff @(posedge clock) begin
      if (cmd.clr_acc) begin
         wr_ff <= '0; wc_ff <= '0; wch_ff <= '0; f_ff <= '0;
         topleft_ff <= slot_add(slot_ff, 1);
         wbase_ff <= slot_add(slot_ff, 1);
         wslot_ff <= slot_add(slot_ff, 1);
         waddr_ff <= '0;
         r0_ff <= IA'(32'(row_ff) - (KERNEL - 1));
         c0_ff <= IA'(32'(col_ff) - (KERNEL - 1));
      end else if (cmd.next_filter) begin
         wr_ff <= '0; wc_ff <= '0; wch_ff <= '0;
         f_ff <= f_ff + 1'b1;
         wbase_ff <= topleft_ff;
         wslot_ff <= topleft_ff;
         waddr_ff <= WA'(32'(f_ff) + 1);
      end else if (cmd.issue && !last_elem) begin
         waddr_ff <= WA'(32'(waddr_ff) + FILTERS);
         if (32'(wch_ff) + 1 < CHANNELS) begin
            wch_ff <= wch_ff + 1'b1;
         end else begin
            wch_ff <= '0;
            if (32'(wc_ff) + 1 < KERNEL) begin
               wc_ff <= wc_ff + 1'b1;
               wslot_ff <= slot_add(wslot_ff, 1);
            end else begin
               wc_ff <= '0;
               wr_ff <= wr_ff + 1'b1;
               wbase_ff <= slot_add(wbase_ff, IMG_SIZE);
               wslot_ff <= slot_add(wbase_ff, IMG_SIZE);
            end
         end
      end
   end

   // read stage, multiply stage, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; acc_ff <= '0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         if (cmd.clr_acc || cmd.next_filter) acc_ff <= '0;
         else if (cmd.add_bias)
            acc_ff <= sat_add(acc_ff, ACC_W'({{(ACC_W-28){bias_ff[15]}}, bias_ff, 12'd0}));
         else if (v2_ff) acc_ff <= sat_add(acc_ff, ACC_W'(prod_ff));
      end
   end
   always_ff @(posedge clock) begin
      px_ff   <= line_mem[LA'(wslot_ff * CHANNELS + wch_ff)];
      w_ff    <= weight_mem[waddr_ff];
      bias_ff <= bias_mem[f_ff];
      prod_ff <= px_ff * w_ff;
   end

   // output register
   logic [ACC_W-13:0] q;
   assign q = acc_ff[ACC_W-1:12];
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (acc_ff <= 0) rsp_activation <= '0;
         else if (q > 32767) rsp_activation <= 15'h7FFF;
         else rsp_activation <= q[14:0];
         rsp_filter_index <= 6'(f_ff);
         rsp_out_row <= 6'(r0_ff);
         rsp_out_col <= 6'(c0_ff);
         rsp_last <= (32'(f_ff) == FILTERS - 1);
      end
   end
endmodule
`default_nettype wire

@@ rtl/c2r_control.sv @@
`default_nettype none
module c2r_control
   import c2r_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [1:0]  req_op,
   output logic             req_stall,
   output logic             req_take,
   input  wire logic        rsp_stall,
   output logic             rsp_valid,
   output c2r_cmd_type      cmd,
   input  wire c2r_stat_type stat
);
   typedef enum logic [2:0] {S_IDLE, S_WALK, S_DRAIN, S_BIAS, S_OUT, S_WAIT} state_type;
   state_type state_ff;
   logic      out_v_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_v_ff;

   logic pix_fire;
   assign pix_fire = req_take && req_op == OP_PIXEL;

   always_comb begin
      cmd = '0;
      cmd.store_pixel = pix_fire;
      cmd.adv_pos     = pix_fire;
      cmd.clr_acc     = pix_fire && stat.pos_last_chan && stat.pos_in_window;
      cmd.issue       = (state_ff == S_WALK);
      cmd.add_bias    = (state_ff == S_BIAS);
      cmd.load_out    = (state_ff == S_OUT) && (!out_v_ff || !rsp_stall);
      cmd.next_filter = cmd.load_out && !stat.filter_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; out_v_ff <= 1'b0;
      end else begin
         if (out_v_ff && !rsp_stall && !cmd.load_out) out_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE:  if (cmd.clr_acc) state_ff <= S_WALK;
            S_WALK:  if (stat.walk_done) state_ff <= S_DRAIN;
            S_DRAIN: if (stat.pipe_empty) state_ff <= S_BIAS;
            S_BIAS:  state_ff <= S_OUT;
            S_OUT: begin
               if (cmd.load_out) begin
                  out_v_ff <= 1'b1;
                  state_ff <= stat.filter_last ? S_WAIT : S_WALK;
               end
            end
            S_WAIT:  if (!out_v_ff || !rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_take) else $error("take while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_v_ff && rsp_stall) |=> out_v_ff) else $error("result lost");
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_acc |=> state_ff == S_WALK) else $error("walk not started");
endmodule
`default_nettype wire

@@ rtl/conv2d_relu_line_buffer_unit.sv @@
`default_nettype none
// Loads and pixels outside the window leave the block idle, ready for the next request.
// A window position holds the input until the last filter's result is taken: per filter
// one product per cycle, then the read/multiply pipe drains, the bias is added and the
// output register is loaded; a stalled result holds the walk.
// Synchronous active-high reset clears position counters and control, not the stores.
module conv2d_relu_line_buffer_unit
   import c2r_pkg::*;
#(
   parameter int IMG_SIZE = 43,
   parameter int CHANNELS = 1,
   parameter int KERNEL   = 11,
   parameter int FILTERS  = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_op,
   input  wire logic [12:0]        req_table_index,
   input  wire logic signed [15:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [14:0]             rsp_activation,
   output logic [5:0]              rsp_filter_index,
   output logic [5:0]              rsp_out_row,
   output logic [5:0]              rsp_out_col,
   output logic                    rsp_last
);
   c2r_cmd_type  cmd;
   c2r_stat_type stat;
   logic         req_take;

   c2r_control u_ctrl (
      .clock, .reset, .req_valid, .req_op, .req_stall, .req_take,
      .rsp_stall, .rsp_valid, .cmd, .stat
   );

   c2r_datapath #(.IMG_SIZE(IMG_SIZE), .CHANNELS(CHANNELS), .KERNEL(KERNEL),
                  .FILTERS(FILTERS)) u_dp (
      .clock, .reset, .req_op, .req_table_index, .req_value, .req_take, .cmd, .stat,
      .rsp_activation, .rsp_filter_index, .rsp_out_row, .rsp_out_col, .rsp_last
   );
endmodule
`default_nettype wire

@@ tb/tb_conv2d_relu_line_buffer_unit.sv @@
`timescale 1ns / 100ps
module tb_conv2d_relu_line_buffer_unit;
   import c2r_pkg::*;

   localparam int IMG   = 43;
   localparam int CHANS = 1;
   localparam int KSZ   = 11;
   localparam int FILTS = 64;
   localparam int WDEPTH = KSZ * KSZ * CHANS * FILTS;
   localparam int LPOS   = IMG * (KSZ - 1) + KSZ;
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam longint SUM_MAX = 64'sd549755813887;
   localparam longint SUM_MIN = -SUM_MAX - 1;

   typedef struct {
      logic [1:0]         op;
      logic [12:0]        idx;
      logic signed [15:0] val;
      bit                 drain;  // hold until all outputs are back
   } req_item_type;

   typedef struct {
      logic [14:0] act;
      logic [5:0]  filt;
      logic [5:0]  row;
      logic [5:0]  col;
      logic        last;
   } act_item_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_op;
   logic [12:0]        req_table_index;
   logic signed [15:0] req_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [14:0]        rsp_activation;
   logic [5:0]         rsp_filter_index;
   logic [5:0]         rsp_out_row;
   logic [5:0]         rsp_out_col;
   logic               rsp_last;

   req_item_type pending_q[$];
   act_item_type expected_acts[$];
   int        fails;
   int        cyc;

   // predictor state
   logic signed [15:0] weight_mem[WDEPTH];
   logic signed [15:0] bias_mem[FILTS];
   logic signed [15:0] line_mem[LPOS*CHANS];
   int                 p_chan, p_row, p_col;

   conv2d_relu_line_buffer_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_table_index(req_table_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_activation(rsp_activation), .rsp_filter_index(rsp_filter_index),
      .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col), .rsp_last(rsp_last)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // two long stretches with no idling on either side
   function automatic bit idle_now();
      bit calm;
      calm = (cyc >= 3000 && cyc < 6000) || (cyc >= 150000 && cyc < 180000);
      return !calm && ($urandom_range(99) < 37);
   endfunction

   function automatic longint sum_sat(longint a, longint b);
      longint s;
      s = a + b;
      if (s > SUM_MAX) return SUM_MAX;
      if (s < SUM_MIN) return SUM_MIN;
      return s;
   endfunction

   // convolution + bias + ReLU for every filter of the window ending here
   task automatic conv_window();
      int        r0, c0, ps;
      longint    acc, tot;
      act_item_type e;
      r0 = p_row - (KSZ - 1);
      c0 = p_col - (KSZ - 1);
      for (int f = 0; f < FILTS; f++) begin
         acc = 0;
         for (int r = 0; r < KSZ; r++)
            for (int c = 0; c < KSZ; c++) begin
               ps = ((r0 + r) * IMG + (c0 + c)) % LPOS;
               for (int ch = 0; ch < CHANS; ch++)
                  acc = sum_sat(acc, longint'(line_mem[ps*CHANS+ch]) *
                        longint'(weight_mem[((r*KSZ+c)*CHANS+ch)*FILTS+f]));
            end
         tot = sum_sat(acc, longint'(bias_mem[f]) * 4096);
         if (tot <= 0) e.act = '0;
         else if ((tot >>> 12) > 32767) e.act = 15'h7fff;
         else e.act = 15'(tot >>> 12);
         e.filt = 6'(f);
         e.row  = 6'(r0);
         e.col  = 6'(c0);
         e.last = (f == FILTS - 1);
         expected_acts.push_back(e);
      end
   endtask

   task automatic apply_item(req_item_type it);
      case (it.op)
         OP_WEIGHT: if (it.idx < WDEPTH) weight_mem[it.idx] = it.val;
         OP_BIAS:   if (it.idx < FILTS) bias_mem[it.idx] = it.val;
         OP_PIXEL: begin
            line_mem[((p_row * IMG + p_col) % LPOS) * CHANS + p_chan] = it.val;
            if (p_chan + 1 < CHANS) begin
               p_chan++;
            end else begin
               p_chan = 0;
               if (p_row >= KSZ - 1 && p_col >= KSZ - 1) conv_window();
               if (p_col + 1 < IMG) begin
                  p_col++;
               end else begin
                  p_col = 0;
                  p_row = (p_row + 1 < IMG) ? p_row + 1 : 0;
               end
            end
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      req_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         cyc <= 0;
      end else begin
         cyc <= cyc + 1;
         if (req_valid && !req_stall) begin
            it.op = req_op;
            it.idx = req_table_index;
            it.val = req_value;
            it.drain = 1'b0;
            apply_item(it);
         end
         if (!(req_valid && req_stall)) begin
            if (pending_q.size() != 0 && !idle_now() &&
                !(pending_q[0].drain && expected_acts.size() != 0)) begin
               it = pending_q.pop_front();
               req_op          <= it.op;
               req_table_index <= it.idx;
               req_value       <= it.val;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      act_item_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_acts.size() == 0) begin
               $error("unexpected output act %0d filter %0d", rsp_activation,
                      rsp_filter_index);
               fails++;
            end else begin
               e = expected_acts.pop_front();
               if (rsp_activation !== e.act) begin
                  $error("activation exp %0d got %0d", e.act, rsp_activation);
                  fails++;
               end
               if (rsp_filter_index !== e.filt) begin
                  $error("filter_index exp %0d got %0d", e.filt, rsp_filter_index);
                  fails++;
               end
               if (rsp_out_row !== e.row) begin
                  $error("out_row exp %0d got %0d", e.row, rsp_out_row);
                  fails++;
               end
               if (rsp_out_col !== e.col) begin
                  $error("out_col exp %0d got %0d", e.col, rsp_out_col);
                  fails++;
               end
               if (rsp_last !== e.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_last);
                  fails++;
               end
            end
         end
         rsp_stall <= idle_now();
      end
   end

   // extremes often, small and full-range values otherwise
   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return '0;
         3: return 16'($signed($urandom_range(32)) - 16);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push(logic [1:0] op, int idx, logic signed [15:0] val, bit drain = 0);
      req_item_type it;
      it.op = op;
      it.idx = 13'(idx);
      it.val = val;
      it.drain = drain;
      pending_q.push_back(it);
   endtask

   // occasional noise or table reload between pixels
   task automatic maybe_noise();
      case ($urandom_range(19))
         0: push(OP_NONE, $urandom_range(8191), 16'($urandom));
         1: push(OP_WEIGHT, $urandom_range(8191, WDEPTH), 16'($urandom));
         2: push(OP_BIAS, $urandom_range(8191, FILTS), 16'($urandom));
         3: push(OP_WEIGHT, $urandom_range(WDEPTH - 1), pick_value());
         4: push(OP_BIAS, $urandom_range(FILTS - 1), pick_value());
         default: ;
      endcase
   endtask

   initial begin
      fails = 0;
      p_chan = 0;
      p_row = 0;
      p_col = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = '0;
      req_table_index = '0;
      req_value = '0;
      rsp_stall = 1'b0;

      // ignored items: unused op, out-of-range table indexes
      push(OP_NONE, 8191, 16'sh7fff);
      push(OP_WEIGHT, 8191, 16'sh8000);
      push(OP_WEIGHT, WDEPTH, 16'sh1234);
      push(OP_BIAS, FILTS, 16'sh7fff);
      push(OP_BIAS, 8191, 16'sh8000);
      // full tables, both extremes in the first entries
      push(OP_WEIGHT, 0, 16'sh7fff);
      push(OP_WEIGHT, 1, 16'sh8000);
      for (int i = 2; i < WDEPTH; i++) push(OP_WEIGHT, i, pick_value());
      push(OP_BIAS, 0, 16'sh7fff);
      push(OP_BIAS, 1, 16'sh8000);
      for (int i = 2; i < FILTS; i++) push(OP_BIAS, i, pick_value());

      // pixels before the first window, with occasional noise and table reloads mixed in
      for (int p = 0; p < (KSZ - 1) * IMG + KSZ - 1; p++) begin
         for (int ch = 0; ch < CHANS; ch++) push(OP_PIXEL, $urandom_range(8191), pick_value());
         maybe_noise();
      end
      // window row; hold the sender off twice until the block drains
      for (int cc = KSZ - 1; cc < IMG; cc++) begin
         for (int ch = 0; ch < CHANS; ch++)
            push(OP_PIXEL, $urandom_range(8191), pick_value(),
                 (cc == KSZ + 5 || cc == KSZ + 20) && ch == 0);
         maybe_noise();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid || expected_acts.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (expected_acts.size() != 0) begin
         $error("%0d outputs never arrived", expected_acts.size());
         fails++;
      end
      if (fails == 0) begin
         $display("tb_conv2d_relu_line_buffer_unit passed");
      end else begin
         $display("tb_conv2d_relu_line_buffer_unit failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #16000000;
      $display("tb_conv2d_relu_line_buffer_unit failed");
      $finish;
   end
endmodule

@@ files.f @@
rtl/c2r_pkg.sv
rtl/c2r_datapath.sv
rtl/c2r_control.sv
rtl/conv2d_relu_line_buffer_unit.sv
tb/tb_conv2d_relu_line_buffer_unit.sv
